// ===== design/least_loaded_slot_allocator_defines.svh =====
// assertion macros for the least loaded slot allocator checker
// depends on clk and rst being visible where the macros are used
`ifndef LEAST_LOADED_SLOT_ALLOCATOR_DEFINES_SVH
`define LEAST_LOADED_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define LLSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llsa check failed");

// next-cycle implication, held off during reset
`define LLSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llsa check failed");

`endif

// ===== design/llsa_pkg.sv =====
// shared constants and types for the least loaded slot allocator
// used by llsa_cell and least_loaded_slot_allocator
package llsa_pkg;

  localparam int NUM_STREAMS_DEF = 8;
  localparam int CREDIT_W        = 8;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 8'd255;
  localparam logic [CREDIT_W-1:0] SLOTS_RESET = 8'd4;
  localparam int INDEX_W         = 3;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_INC,
    OP_DEC
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CREDIT_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/least_loaded_slot_allocator.sv =====
// least loaded slot allocator: credit counters in a chain of compare cells
// acquire: the result is set by the scan through the cell chain, one cell per cycle,
// then registered in the commit state; release: skips the scan and goes to commit
// one request at a time: no new request until the result is committed, which waits on output stalls
// reset: every counter at 4, round robin pointer 0, no result pending
// depends on llsa_pkg and llsa_cell
module least_loaded_slot_allocator import llsa_pkg::*; #(
  parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [2:0] stream_index, [7:3] zero
  input  logic [0:0] s_axis_tuser,   // [0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] grant_valid, [3:1] granted_stream,
                                     // [4] release_overflow, [7:5] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data        // [7:0] slots_per_stream
);

  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int IW = (SW > INDEX_W) ? SW : INDEX_W;
  localparam int CW = $clog2(NUM_STREAMS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t              state;
  logic [CW-1:0]       scan_cnt;
  logic                req_mode;
  logic [INDEX_W-1:0]  req_index;
  logic [CREDIT_W-1:0] slots_per_stream;
  logic [SW-1:0]       rr_pointer;
  logic [7:0]          out_data;

  logic [CREDIT_W-1:0] chain_val [NUM_STREAMS+1];
  logic [SW-1:0]       chain_idx [NUM_STREAMS+1];
  logic [NUM_STREAMS-1:0] sel;
  logic [NUM_STREAMS-1:0] at_max;
  cell_cmd_t           cmd;
  logic                out_free;
  logic                commit;
  logic                rel_hit;
  logic                rel_ovf;
  logic                credit_grant;
  logic [SW-1:0]       best_idx;

  assign chain_val[0] = '0;
  assign chain_idx[0] = '0;
  assign best_idx     = chain_idx[NUM_STREAMS];

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = out_data;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign commit        = (state == S_COMMIT) && out_free;

  always_comb begin
    for (int i = 0; i < NUM_STREAMS; i++) begin
      if (req_mode == MODE_RELEASE) begin
        sel[i] = (IW'(req_index) == IW'(i));
      end else begin
        sel[i] = (best_idx == SW'(i));
      end
    end
  end

  assign rel_hit      = |sel;
  assign rel_ovf      = |(sel & at_max);
  assign credit_grant = (slots_per_stream != '0) && (chain_val[NUM_STREAMS] != '0);

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.value = cfg_data;
    if (cfg_valid && cfg_ready) begin
      cmd.op = OP_LOAD;
    end else if (commit) begin
      if (req_mode == MODE_RELEASE) begin
        if (rel_hit) cmd.op = OP_INC;
      end else if (credit_grant) begin
        cmd.op = OP_DEC;
      end
    end
  end

  for (genvar g = 0; g < NUM_STREAMS; g++) begin : g_cell
    llsa_cell #(
      .IDX_W (SW),
      .IDX   (g)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .sel          (sel[g]),
      .best_val_in  (chain_val[g]),
      .best_idx_in  (chain_idx[g]),
      .best_val_out (chain_val[g+1]),
      .best_idx_out (chain_idx[g+1]),
      .at_max       (at_max[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      scan_cnt         <= '0;
      slots_per_stream <= SLOTS_RESET;
      rr_pointer       <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) slots_per_stream <= cfg_data;
      if (commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_mode  <= s_axis_tuser[0];
            req_index <= s_axis_tdata[INDEX_W-1:0];
            scan_cnt  <= '0;
            state     <= (s_axis_tuser[0] == MODE_RELEASE) ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == CW'(NUM_STREAMS - 1)) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            if (req_mode == MODE_RELEASE) begin
              out_data <= {3'b000, rel_ovf, 4'b0000};
            end else if (slots_per_stream == '0) begin
              out_data   <= {4'b0000, INDEX_W'(rr_pointer), 1'b1};
              rr_pointer <= (rr_pointer == SW'(NUM_STREAMS - 1)) ? '0 : rr_pointer + 1'b1;
            end else if (credit_grant) begin
              out_data <= {4'b0000, INDEX_W'(best_idx), 1'b1};
            end else begin
              out_data <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/llsa_cell.sv =====
// one credit counter of the allocator chain with its compare stage
// depends on llsa_pkg
module llsa_cell import llsa_pkg::*; #(
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_cmd_t           cmd,
  input  logic                sel,
  input  logic [CREDIT_W-1:0] best_val_in,
  input  logic [IDX_W-1:0]    best_idx_in,
  output logic [CREDIT_W-1:0] best_val_out,
  output logic [IDX_W-1:0]    best_idx_out,
  output logic                at_max
);

  logic [CREDIT_W-1:0] credit;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= SLOTS_RESET;
    end else begin
      case (cmd.op)
        OP_LOAD: credit <= cmd.value;
        OP_INC: begin
          if (sel && credit != CREDIT_MAX) credit <= credit + 1'b1;
        end
        OP_DEC: begin
          if (sel && credit != '0) credit <= credit - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (credit > best_val_in) begin
      best_val_out <= credit;
      best_idx_out <= IDX_W'(IDX);
    end else begin
      best_val_out <= best_val_in;
      best_idx_out <= best_idx_in;
    end
  end

  assign at_max = (credit == CREDIT_MAX);

endmodule

// ===== design/llsa_check.sv =====
// port-level checker for the least loaded slot allocator, bound to the top level
// depends on least_loaded_slot_allocator_defines.svh
`include "least_loaded_slot_allocator_defines.svh"

module llsa_check (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic [0:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_data
);

  `LLSA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LLSA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
  `LLSA_ASSERT_IMP(a_no_grant_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[3:1] == 3'd0)
  `LLSA_ASSERT_IMP(a_grant_or_ovf, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[4]))

endmodule

bind least_loaded_slot_allocator llsa_check u_llsa_check (.*);
